@@ rtl/core/mfba_pkg.sv @@
// ----------------------------------------------------------------------------
// mfba_pkg
// Types and constants shared by the max-flow engine modules.
// ----------------------------------------------------------------------------
package mfba_pkg;

  localparam int NODE_BITS = 6;
  localparam int NODES     = 1 << NODE_BITS;
  localparam int CAP_BITS  = 16;
  localparam int FLOW_BITS = CAP_BITS + 1;
  localparam int TOTAL_BITS = 22;
  localparam int ADDR_BITS = 2 * NODE_BITS;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RUN   = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_SAME_NODE = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic [NODE_BITS-1:0] from_node;
    logic [NODE_BITS-1:0] to_node;
    logic [CAP_BITS-1:0]  capacity;
  } mfba_in_t;

  typedef struct packed {
    logic [TOTAL_BITS-1:0] max_flow;
    logic                  status;
  } mfba_out_t;

  // One access to the edge stores: capacity and net flow share an address.
  typedef struct packed {
    logic                        cap_we;
    logic                        flow_we;
    logic [ADDR_BITS-1:0]        waddr;
    logic [CAP_BITS-1:0]         cap_wdata;
    logic signed [FLOW_BITS-1:0] flow_wdata;
    logic [ADDR_BITS-1:0]        raddr;
  } mfba_edge_req_t;

endpackage

@@ rtl/core/mfba_edge_mem.sv @@
// ----------------------------------------------------------------------------
// mfba_edge_mem
// Node-by-node capacity and net-flow memories, one write and one read port
// each, registered read data.
// ----------------------------------------------------------------------------
module mfba_edge_mem (
  input  logic                                clk,
  input  mfba_pkg::mfba_edge_req_t            req,
  output logic [mfba_pkg::CAP_BITS-1:0]       cap_rdata,
  output logic signed [mfba_pkg::FLOW_BITS-1:0] flow_rdata
);
  import mfba_pkg::*;

  logic [CAP_BITS-1:0]         cap_mem  [NODES*NODES];
  logic signed [FLOW_BITS-1:0] flow_mem [NODES*NODES];

  always_ff @(posedge clk) begin
    if (req.cap_we) begin
      cap_mem[req.waddr] <= req.cap_wdata;
    end
    cap_rdata <= cap_mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (req.flow_we) begin
      flow_mem[req.waddr] <= req.flow_wdata;
    end
    flow_rdata <= flow_mem[req.raddr];
  end

endmodule

@@ rtl/core/max_flow_bfs_augment.sv @@
// ----------------------------------------------------------------------------
// max_flow_bfs_augment
// Edmonds-Karp maximum flow over a 64-node capacity memory.
// ----------------------------------------------------------------------------
// A capacity write leaves busy low, so writes can follow back to back.
// A run starts with a clear of the net-flow memory; a source equal to the sink reports
// right after it. Otherwise each augmenting path takes a search setup, a scan of all nodes
// per dequeued node and a final check, then a bottleneck walk and a flow-update walk back
// along the path edges; the search that finds no path reports. After reset busy stays high
// for a clearing pass of both memories; the strobe lasts one cycle.
// ----------------------------------------------------------------------------
module max_flow_bfs_augment (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mfba_pkg::mfba_in_t  in_word,
  output logic                out_valid,
  output mfba_pkg::mfba_out_t out_word
);
  import mfba_pkg::*;

  typedef enum logic [3:0] {
    S_INIT,      // clearing pass of both memories after reset
    S_IDLE,
    S_CLEAR,     // zero the net-flow memory at run start
    S_BFS_INIT,  // clear visited bits, seed queue
    S_DEQ,       // take the next queue entry
    S_SCAN,      // issue reads of (x, y) residuals
    S_WALK1P,    // bottleneck walk, fetch the parent of the node
    S_WALK1,     // bottleneck walk, read edge parent->node
    S_WALK1W,
    S_WALK2P,    // augment walk: fetch the parent of the node
    S_WALK2,     // augment walk: read forward flow
    S_WALK2F,
    S_WALK2B     // write back the backward flow
  } state_t;

  state_t state_r;

  // Edge memory request and read data.
  mfba_edge_req_t               req;
  logic [CAP_BITS-1:0]          cap_rd;
  logic signed [FLOW_BITS-1:0]  flow_rd;

  mfba_edge_mem u_edge_mem (
    .clk        (clk),
    .req        (req),
    .cap_rdata  (cap_rd),
    .flow_rdata (flow_rd)
  );

  // Search state: visited bits in flip-flops, parents and queue in small
  // memories read at one address each, with registered read data.
  logic [NODES-1:0]      visited_r;
  logic [NODE_BITS-1:0]  parent_mem [NODES];
  logic [NODE_BITS-1:0]  queue_mem  [NODES];

  logic [ADDR_BITS:0]    sweep_r;
  logic [NODE_BITS-1:0]  src_r, snk_r;
  logic [NODE_BITS:0]    head_r, tail_r;
  logic [NODE_BITS-1:0]  x_r;
  logic [NODE_BITS:0]    y_r;          // scan index, issued read
  logic                  rd_vld_r;     // a scan read is in flight
  logic [NODE_BITS-1:0]  y_rd_r;       // node of in-flight read
  logic [NODE_BITS-1:0]  node_r, par_r;
  logic [FLOW_BITS-1:0]  bneck_r;
  logic [TOTAL_BITS-1:0] total_r;
  logic [NODE_BITS-1:0]  q_head_r;
  logic [NODE_BITS-1:0]  parent_rd_r;

  // Residual of the read pair; capacity minus net flow, always >= 0 here.
  logic signed [FLOW_BITS+1:0] resid;
  assign resid = $signed({2'b00, cap_rd}) - $signed({flow_rd[FLOW_BITS-1], flow_rd});

  // Queue and parent writes happen when a scan read returns an unvisited
  // node with positive residual.
  logic hit;
  assign hit = (state_r == S_SCAN) && rd_vld_r && !visited_r[y_rd_r] && (resid > 0);

  // A run reports either right after the clear (source equals sink) or when
  // a search ends without reaching the sink.
  logic run_same_done;
  logic run_flow_done;
  assign run_same_done = (state_r == S_CLEAR) &&
                         (sweep_r == (ADDR_BITS+1)'(NODES*NODES-1)) && (src_r == snk_r);
  assign run_flow_done = (state_r == S_DEQ) && (head_r == tail_r) && !visited_r[snk_r];

  always_ff @(posedge clk) begin
    if (hit) begin
      parent_mem[y_rd_r] <= x_r;
      queue_mem[tail_r[NODE_BITS-1:0]] <= y_rd_r;
    end
    q_head_r    <= queue_mem[head_r[NODE_BITS-1:0]];
    parent_rd_r <= parent_mem[node_r];
  end

  // Memory request mux.
  always_comb begin
    req = '0;
    unique case (state_r)
      S_INIT: begin
        req.cap_we  = 1'b1;
        req.flow_we = 1'b1;
        req.waddr   = sweep_r[ADDR_BITS-1:0];
      end
      S_IDLE: begin
        req.cap_we    = start && (in_word.operation == OP_WRITE);
        req.waddr     = {in_word.from_node, in_word.to_node};
        req.cap_wdata = in_word.capacity;
      end
      S_CLEAR: begin
        req.flow_we = 1'b1;
        req.waddr   = sweep_r[ADDR_BITS-1:0];
      end
      S_SCAN:  req.raddr = {x_r, y_r[NODE_BITS-1:0]};
      S_WALK1: req.raddr = {parent_rd_r, node_r};
      S_WALK2: req.raddr = {parent_rd_r, node_r};
      S_WALK2F: begin
        // Forward flow arrives now; write it back, read the backward entry.
        req.flow_we    = 1'b1;
        req.waddr      = {par_r, node_r};
        req.flow_wdata = flow_rd + $signed(bneck_r);
        req.raddr      = {node_r, par_r};
      end
      S_WALK2B: begin
        req.flow_we    = 1'b1;
        req.waddr      = {node_r, par_r};
        req.flow_wdata = flow_rd - $signed(bneck_r);
      end
      default: req = '0;
    endcase
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_INIT;
      sweep_r   <= '0;
      out_valid <= 1'b0;
      visited_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      out_valid <= run_same_done || run_flow_done;
      unique case (state_r)
        S_INIT: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == (ADDR_BITS+1)'(NODES*NODES-1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start && in_word.operation == OP_RUN) begin
            src_r   <= in_word.from_node;
            snk_r   <= in_word.to_node;
            total_r <= '0;
            sweep_r <= '0;
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          sweep_r <= sweep_r + 1'b1;
          if (sweep_r == (ADDR_BITS+1)'(NODES*NODES-1)) begin
            if (src_r == snk_r) begin
              out_word.max_flow <= '0;
              out_word.status   <= STATUS_SAME_NODE;
              state_r           <= S_IDLE;
            end else begin
              state_r <= S_BFS_INIT;
            end
          end
        end
        S_BFS_INIT: begin
          visited_r <= NODES'(1'b1) << src_r;
          head_r    <= '0;
          tail_r    <= (NODE_BITS+1)'(1);
          state_r   <= S_DEQ;
        end
        S_DEQ: begin
          if (head_r == tail_r) begin
            if (visited_r[snk_r]) begin
              node_r  <= snk_r;
              bneck_r <= '1;
              state_r <= S_WALK1P;
            end else begin
              out_word.max_flow <= total_r;
              out_word.status   <= STATUS_OK;
              state_r           <= S_IDLE;
            end
          end else begin
            // The first entry is the source itself; it is never written to the
            // queue memory, so it is taken straight from the register.
            x_r      <= (head_r == '0) ? src_r : q_head_r;
            head_r   <= head_r + 1'b1;
            y_r      <= '0;
            rd_vld_r <= 1'b0;
            state_r  <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            visited_r[y_rd_r] <= 1'b1;
            tail_r <= tail_r + 1'b1;
          end
          if (y_r == (NODE_BITS+1)'(NODES)) begin
            rd_vld_r <= 1'b0;
            if (!rd_vld_r) begin
              state_r <= S_DEQ;
            end
          end else begin
            rd_vld_r <= 1'b1;
            y_rd_r   <= y_r[NODE_BITS-1:0];
            y_r      <= y_r + 1'b1;
          end
        end
        S_WALK1P: begin
          state_r <= S_WALK1;
        end
        S_WALK1: begin
          par_r   <= parent_rd_r;
          state_r <= S_WALK1W;
        end
        S_WALK1W: begin
          if (FLOW_BITS'(resid) < bneck_r) begin
            bneck_r <= FLOW_BITS'(resid);
          end
          if (par_r == src_r) begin
            node_r  <= snk_r;
            state_r <= S_WALK2P;
          end else begin
            node_r  <= par_r;
            state_r <= S_WALK1P;
          end
        end
        S_WALK2P: begin
          state_r <= S_WALK2;
        end
        S_WALK2: begin
          par_r   <= parent_rd_r;
          state_r <= S_WALK2F;
        end
        S_WALK2F: begin
          state_r <= S_WALK2B;
        end
        S_WALK2B: begin
          if (par_r == src_r) begin
            total_r <= total_r + TOTAL_BITS'(bneck_r);
            state_r <= S_BFS_INIT;
          end else begin
            node_r  <= par_r;
            state_r <= S_WALK2P;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
